// File: hw/rtl/bdq_pkg.sv
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned PW    = 4;
  localparam int unsigned VW    = 32;
  localparam int unsigned CMPW  = (PW > CW) ? PW : CW;

  localparam logic [2:0] REQ_PUSH_TAIL = 3'd0;
  localparam logic [2:0] REQ_POP_HEAD  = 3'd1;
  localparam logic [2:0] REQ_PUSH_HEAD = 3'd2;
  localparam logic [2:0] REQ_FIND      = 3'd3;
  localparam logic [2:0] REQ_READ      = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]           req_type;
    logic signed [VW-1:0] value;
    logic [PW-1:0]        position;
  } bdq_in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic signed [VW-1:0] data;
    logic [PW-1:0]        found_position;
    logic [4:0]           count;
  } bdq_out_t;

  // ring slot of an offset from the head, offset at most DEPTH
  function automatic logic [AW-1:0] slot_of(logic [AW-1:0] head, logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW + 1)'(head) + (CW + 1)'(off);
    if (s >= (CW + 1)'(DEPTH)) begin
      s = s - (CW + 1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

endpackage

// File: hw/rtl/bdq_ram.sv
`timescale 1ns / 1ps

module bdq_ram #(
  parameter int unsigned DATA_W  = 32,
  parameter int unsigned DEPTH_N = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH_N > 1) ? $clog2(DEPTH_N) : 1)-1:0] waddr,
  input  logic [DATA_W-1:0]                         wdata,
  input  logic [((DEPTH_N > 1) ? $clog2(DEPTH_N) : 1)-1:0] raddr,
  output logic [DATA_W-1:0]                         rdata
);

  logic [DATA_W-1:0] mem [DEPTH_N];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/bounded_deque_with_search.sv
`timescale 1ns / 1ps
// Push and every refused or failed request answer via the output register only; pop and read
// also pass the store read; find makes one store read per cycle, walking from the head.
// busy is high in S_READ or S_FIND, until the cycle before the strobe; one request at a time.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// Reset (rst_n low, synchronous) empties the deque; store contents stay undefined.
module bounded_deque_with_search
  import bdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  bdq_in_t  in_req,
  output logic     out_valid,
  output bdq_out_t out_res
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_FIND = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [AW-1:0]        head_r, head_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic signed [VW-1:0] val_r, val_nxt;
  logic                 out_valid_r, out_valid_nxt;
  bdq_out_t             out_r, out_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [VW-1:0]        ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [VW-1:0]        ram_rdata;

  logic                 imm;
  bdq_out_t             res;
  logic [CW-1:0]        idx_inc;

  bdq_ram #(
    .DATA_W (VW),
    .DEPTH_N(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign idx_inc = CW'(idx_r + 1'b1);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = head_r;
    ram_wdata     = in_req.value;
    ram_raddr     = head_r;
    imm           = 1'b0;
    res           = '0;
    res.status    = ST_OK;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          val_nxt = in_req.value;
          case (in_req.req_type)
            REQ_PUSH_TAIL: begin
              imm = 1'b1;
              if (count_r == CW'(DEPTH)) begin
                res.status = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = slot_of(head_r, count_r);
                count_nxt = CW'(count_r + 1'b1);
              end
            end
            REQ_PUSH_HEAD: begin
              imm = 1'b1;
              if (count_r == CW'(DEPTH)) begin
                res.status = ST_FULL;
              end else begin
                head_nxt  = slot_of(head_r, CW'(DEPTH - 1));
                ram_we    = 1'b1;
                ram_waddr = head_nxt;
                count_nxt = CW'(count_r + 1'b1);
              end
            end
            REQ_POP_HEAD: begin
              if (count_r == '0) begin
                imm        = 1'b1;
                res.status = ST_MISS;
              end else begin
                ram_raddr = head_r;
                head_nxt  = slot_of(head_r, CW'(1));
                count_nxt = CW'(count_r - 1'b1);
                state_nxt = S_READ;
              end
            end
            REQ_FIND: begin
              if (count_r == '0) begin
                imm        = 1'b1;
                res.status = ST_MISS;
              end else begin
                ram_raddr = head_r;
                idx_nxt   = '0;
                state_nxt = S_FIND;
              end
            end
            REQ_READ: begin
              if (CMPW'(in_req.position) < CMPW'(count_r)) begin
                ram_raddr = slot_of(head_r, CW'(in_req.position));
                state_nxt = S_READ;
              end else begin
                imm        = 1'b1;
                res.status = ST_MISS;
              end
            end
            default: begin
              imm        = 1'b1;
              res.status = ST_MISS;
            end
          endcase
          if (imm) begin
            res.count     = 5'(count_nxt);
            out_nxt       = res;
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_READ: begin
        res.data      = ram_rdata;
        res.count     = 5'(count_r);
        out_nxt       = res;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_FIND: begin
        res.count = 5'(count_r);
        if ($signed(ram_rdata) == val_r) begin
          res.found_position = PW'(idx_r);
          out_nxt            = res;
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end else if (idx_inc == count_r) begin
          res.status    = ST_MISS;
          out_nxt       = res;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ram_raddr = slot_of(head_r, idx_inc);
          idx_nxt   = idx_inc;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    val_r <= val_nxt;
    out_r <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

// File: tb/sv/bounded_deque_with_search_tb.sv
`timescale 1ns / 1ps

module bounded_deque_with_search_tb;
  import bdq_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  bdq_in_t  in_req;
  logic     out_valid;
  bdq_out_t out_res;

  bounded_deque_with_search uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // mirror of the deque
  logic signed [VW-1:0] ring [DEPTH];
  int unsigned          head_slot;
  int unsigned          held;

  bdq_out_t expected_replies[$];
  bdq_out_t next_reply;
  int       mismatches;
  bit       idle_on;

  logic signed [VW-1:0] value_pool [6] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0,
                                          -32'sd1, 32'sd5, 32'sd42};

  function automatic int unsigned ring_slot(int unsigned off);
    return (head_slot + off) % DEPTH;
  endfunction

  function automatic bdq_out_t predict_deque(bdq_in_t r);
    bdq_out_t o;
    bit       hit;
    o   = '0;
    hit = 1'b0;
    case (r.req_type)
      REQ_PUSH_TAIL: begin
        if (held >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          ring[ring_slot(held)] = r.value;
          held++;
        end
      end
      REQ_POP_HEAD: begin
        if (held == 0) begin
          o.status = ST_MISS;
        end else begin
          o.data    = ring[head_slot];
          head_slot = ring_slot(1);
          held--;
        end
      end
      REQ_PUSH_HEAD: begin
        if (held >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          head_slot       = ring_slot(DEPTH - 1);
          ring[head_slot] = r.value;
          held++;
        end
      end
      REQ_FIND: begin
        o.status = ST_MISS;
        for (int unsigned i = 0; i < held; i++) begin
          if (!hit && ring[ring_slot(i)] == r.value) begin
            hit              = 1'b1;
            o.status         = ST_OK;
            o.found_position = PW'(i);
          end
        end
      end
      REQ_READ: begin
        if (r.position < held) begin
          o.data = ring[ring_slot(r.position)];
        end else begin
          o.status = ST_MISS;
        end
      end
      default: begin
        o.status = ST_MISS;
      end
    endcase
    o.count = 5'(held);
    return o;
  endfunction

  // one transaction; start is assigned exactly once per cycle until accepted
  task automatic send_req(bdq_in_t r);
    bit done;
    done = 1'b0;
    while (!done) begin
      if (idle_on && $urandom_range(99) < 36) begin
        start <= 1'b0;
      end else begin
        start  <= 1'b1;
        in_req <= r;
      end
      @(posedge clk);
      if (start && !busy) begin
        expected_replies.push_back(predict_deque(in_req));
        done = 1'b1;
      end
    end
  endtask

  task automatic send_op(logic [2:0] op, logic signed [VW-1:0] v, logic [PW-1:0] p);
    bdq_in_t r;
    r.req_type = op;
    r.value    = v;
    r.position = p;
    send_req(r);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected result transaction: status %0d data %0d count %0d",
               out_res.status, out_res.data, out_res.count);
        mismatches++;
      end else begin
        next_reply = expected_replies.pop_front();
        if (out_res.status !== next_reply.status) begin
          $error("status: expected %0d, actual %0d", next_reply.status, out_res.status);
          mismatches++;
        end
        if (out_res.data !== next_reply.data) begin
          $error("data: expected %0d, actual %0d", next_reply.data, out_res.data);
          mismatches++;
        end
        if (out_res.found_position !== next_reply.found_position) begin
          $error("found_position: expected %0d, actual %0d",
                 next_reply.found_position, out_res.found_position);
          mismatches++;
        end
        if (out_res.count !== next_reply.count) begin
          $error("count: expected %0d, actual %0d", next_reply.count, out_res.count);
          mismatches++;
        end
      end
    end
  end

  // requests on an empty deque, incl. unknown request types
  task automatic test_empty;
    send_op(REQ_POP_HEAD, 32'sd0, 4'd0);
    send_op(REQ_FIND, 32'sd0, 4'd0);
    send_op(REQ_READ, 32'sd0, 4'd0);
    send_op(3'd5, -32'sd1, 4'd15);
    send_op(3'd7, 32'sd0, 4'd0);
  endtask

  // extreme values at both ends, find hit and miss, read in and beyond range
  task automatic test_extremes;
    send_op(REQ_PUSH_TAIL, 32'sh8000_0000, 4'd0);
    send_op(REQ_PUSH_HEAD, 32'sh7fff_ffff, 4'd15);
    send_op(REQ_PUSH_TAIL, 32'sd0, 4'd0);
    send_op(REQ_PUSH_HEAD, -32'sd1, 4'd0);
    send_op(REQ_FIND, 32'sh8000_0000, 4'd0);
    send_op(REQ_FIND, 32'sd12345, 4'd0);
    send_op(REQ_READ, 32'sd0, 4'd3);
    send_op(REQ_READ, 32'sd0, 4'd4);
    send_op(REQ_POP_HEAD, 32'sd0, 4'd0);
  endtask

  // fill to capacity, then refused pushes at both ends
  task automatic test_full;
    for (int k = 0; k < 13; k++) begin
      send_op((k % 2) ? REQ_PUSH_HEAD : REQ_PUSH_TAIL, 32'(k * 7 - 30), 4'd0);
    end
    send_op(REQ_PUSH_TAIL, 32'sd99, 4'd0);
    send_op(REQ_PUSH_HEAD, 32'sd99, 4'd0);
    send_op(REQ_READ, 32'sd0, 4'd15);
  endtask

  // bursts biased towards filling, draining, mixing or searching
  task automatic test_random(int n_items, bit gaps);
    bdq_in_t r;
    int      mode;
    int      left;
    int      roll;
    int      c_tail;
    int      c_head;
    int      c_pop;
    int      c_find;
    int      c_read;
    idle_on = gaps;
    left    = 0;
    mode    = 0;
    for (int k = 0; k < n_items; k++) begin
      if (left == 0) begin
        mode = $urandom_range(3);
        left = $urandom_range(60, 15);
      end
      left--;
      case (mode)
        0:       begin c_tail = 35; c_head = 65; c_pop = 72; c_find = 84; c_read = 97; end
        1:       begin c_tail = 10; c_head = 18; c_pop = 70; c_find = 84; c_read = 97; end
        2:       begin c_tail = 20; c_head = 40; c_pop = 60; c_find = 78; c_read = 97; end
        default: begin c_tail = 10; c_head = 20; c_pop = 32; c_find = 75; c_read = 95; end
      endcase
      roll       = $urandom_range(99);
      r.position = PW'($urandom_range(15));
      r.value    = $urandom_range(1) ? $signed($urandom) : value_pool[$urandom_range(5)];
      if (roll < c_tail)      r.req_type = REQ_PUSH_TAIL;
      else if (roll < c_head) r.req_type = REQ_PUSH_HEAD;
      else if (roll < c_pop)  r.req_type = REQ_POP_HEAD;
      else if (roll < c_find) r.req_type = REQ_FIND;
      else if (roll < c_read) r.req_type = REQ_READ;
      else                    r.req_type = 3'($urandom_range(7, 5));
      if (r.req_type == REQ_FIND && held > 0 && $urandom_range(99) < 60) begin
        r.value = ring[ring_slot($urandom_range(held - 1))];
      end
      send_req(r);
    end
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) ring[i] = '0;
    head_slot  = 0;
    held       = 0;
    mismatches = 0;
    idle_on    = 1'b1;
    rst_n  <= 1'b0;
    start  <= 1'b0;
    in_req <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_empty();
    test_extremes();
    test_full();
    test_random(550, 1'b1);
    test_random(300, 1'b0);
    test_random(270, 1'b1);

    start <= 1'b0;
    for (int w = 0; w < 2000 && expected_replies.size() > 0; w++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (expected_replies.size() != 0) begin
        $error("%0d result transactions never arrived", expected_replies.size());
      end
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $error("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_ram.sv
hw/rtl/bounded_deque_with_search.sv
tb/sv/bounded_deque_with_search_tb.sv
